FILE: rtl/core/ratnorm_pkg.sv
// ratnorm_pkg: shared types for the rational normalizer
// command and status bundles between controller and datapath; no dependencies

package ratnorm_pkg;

	// operand pair fed to the shared divider
	typedef enum logic [1:0] {
		DIV_GCD = 2'd0,
		DIV_NUM = 2'd1,
		DIV_DEN = 2'd2
	} div_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t sel;
		logic     gcd_step;
		logic     rn_take;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic special;
		logic b_zero;
		logic div_done;
	} status_t;

endpackage

FILE: rtl/core/ratnorm_div.sv
// ratnorm_div: restoring unsigned divider, one quotient bit per cycle
// standalone; used by ratnorm_dp

module ratnorm_div #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quot,
	output logic [WIDTH-1:0] rem
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH:0]   rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   rem_sh;
	logic [WIDTH+1:0] diff;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		ge     = ~diff[WIDTH+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WIDTH:0] : rem_sh;
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q[WIDTH-1:0];

endmodule

FILE: rtl/core/ratnorm_dp.sv
// ratnorm_dp: datapath of the rational normalizer
// magnitudes, euclid registers, shared divider and result register; uses ratnorm_pkg, ratnorm_div

module ratnorm_dp #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ratnorm_pkg::cmd_t   cmd,
	output ratnorm_pkg::status_t sts,
	input  logic [WIDTH-1:0]    num_in,
	input  logic [WIDTH-1:0]    den_in,
	output logic [WIDTH-1:0]    num_out,
	output logic [WIDTH-2:0]    den_out,
	output logic                zero_den_error
);

	logic [WIDTH-1:0] nmag_q, dmag_q, a_q, b_q, rn_q;
	logic             neg_q, err_q, zero_q;
	logic [WIDTH-1:0] n_mag, d_mag;
	logic [WIDTH-1:0] dvd, dvs, quot, rem;
	logic             div_done;
	logic [WIDTH-1:0] num_r_q;
	logic [WIDTH-2:0] den_r_q;
	logic             err_r_q;

	assign n_mag = num_in[WIDTH-1] ? (~num_in + 1'b1) : num_in;
	assign d_mag = den_in[WIDTH-1] ? (~den_in + 1'b1) : den_in;

	always_comb begin
		case (cmd.sel)
			ratnorm_pkg::DIV_GCD: begin
				dvd = a_q;
				dvs = b_q;
			end
			ratnorm_pkg::DIV_NUM: begin
				dvd = nmag_q;
				dvs = a_q;
			end
			ratnorm_pkg::DIV_DEN: begin
				dvd = dmag_q;
				dvs = a_q;
			end
			default: begin
				dvd = a_q;
				dvs = b_q;
			end
		endcase
	end

	ratnorm_div #(.WIDTH(WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nmag_q <= n_mag;
			dmag_q <= d_mag;
			a_q    <= n_mag;
			b_q    <= d_mag;
			neg_q  <= num_in[WIDTH-1] ^ den_in[WIDTH-1];
			err_q  <= (d_mag == '0);
			zero_q <= (n_mag == '0);
		end else if (cmd.gcd_step) begin
			a_q <= b_q;
			b_q <= rem;
		end
		if (cmd.rn_take)
			rn_q <= quot;
	end

	// result register: 0/1 for a zero numerator or denominator; saturate magnitudes of 2^(WIDTH-1) where they do not fit
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (err_q || zero_q) begin
				num_r_q <= '0;
				den_r_q <= (WIDTH-1)'(1);
				err_r_q <= err_q;
			end else begin
				den_r_q <= quot[WIDTH-1] ? {(WIDTH-1){1'b1}} : quot[WIDTH-2:0];
				if (neg_q)
					num_r_q <= ~rn_q + 1'b1;
				else
					num_r_q <= rn_q[WIDTH-1] ? {1'b0, {(WIDTH-1){1'b1}}} : rn_q;
				err_r_q <= 1'b0;
			end
		end
	end

	assign sts.special  = err_q | zero_q;
	assign sts.b_zero   = (b_q == '0);
	assign sts.div_done = div_done;

	assign num_out        = num_r_q;
	assign den_out        = den_r_q;
	assign zero_den_error = err_r_q;

endmodule

FILE: rtl/core/ratnorm_ctrl.sv
// ratnorm_ctrl: sequencer of the rational normalizer
// runs euclid steps and the two reducing divisions, owns out_valid; uses ratnorm_pkg

module ratnorm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ratnorm_pkg::status_t sts,
	output ratnorm_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_GCD_CHK,
		S_GCD_WAIT,
		S_NUM_WAIT,
		S_DEN_WAIT,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.sel = ratnorm_pkg::DIV_GCD;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_GCD_CHK: begin
				cmd.div_start = 1'b1;
				cmd.sel = sts.b_zero ? ratnorm_pkg::DIV_NUM : ratnorm_pkg::DIV_GCD;
			end
			S_GCD_WAIT: cmd.gcd_step = sts.div_done;
			S_NUM_WAIT: begin
				cmd.rn_take   = sts.div_done;
				cmd.div_start = sts.div_done;
				cmd.sel       = ratnorm_pkg::DIV_DEN;
			end
			S_OUT: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result wins over the hand-off of the old one
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CHECK;
				S_CHECK: state_q <= sts.special ? S_OUT : S_GCD_CHK;
				S_GCD_CHK: state_q <= sts.b_zero ? S_NUM_WAIT : S_GCD_WAIT;
				S_GCD_WAIT: if (sts.div_done) state_q <= S_GCD_CHK;
				S_NUM_WAIT: if (sts.div_done) state_q <= S_DEN_WAIT;
				S_DEN_WAIT: if (sts.div_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/rational_normalizer_unit.sv
// rational_normalizer_unit: top level of the rational normalizer
// joins ratnorm_ctrl and ratnorm_dp; uses ratnorm_pkg
//
// usage notes
// - input channel: in_valid/in_ready with num_in, den_in (signed two's complement)
// - output channel: out_valid/out_ready with num_out (signed), den_out (positive),
//   zero_den_error; each accepted item gives exactly one result item
// - one item in flight; in_ready is high only while the sequencer is idle
// - zero numerator or zero denominator skips the divider and goes to the output register;
//   otherwise the item takes k euclid remainder steps and the two reducing divisions,
//   each a full pass of the shared one-bit-per-cycle divider
// - the sequencer goes back to idle when the result register loads; the next item
//   can be taken from then on
// - a finished result sits in the output register; the next item is accepted
//   while it waits, and that item's result is held back until the old one is taken
// - reset (arst_n low) clears the sequencer and out_valid at once

module rational_normalizer_unit #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] num_in,
	input  logic [WIDTH-1:0] den_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] num_out,
	output logic [WIDTH-2:0] den_out,
	output logic             zero_den_error
);

	// command and status bundles between sequencer and datapath
	ratnorm_pkg::cmd_t    cmd;
	ratnorm_pkg::status_t sts;

	// sequencer: load, euclid loop, two reducing divisions, result hand-off
	ratnorm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: magnitudes, gcd registers, shared divider, saturating result register
	ratnorm_dp #(.WIDTH(WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.num_in         (num_in),
		.den_in         (den_in),
		.num_out        (num_out),
		.den_out        (den_out),
		.zero_den_error (zero_den_error)
	);

endmodule

FILE: dv/rational_normalizer_unit_tb.sv
`timescale 1ns / 100ps
// rational_normalizer_unit_tb: self-checking bench for the rational normalizer
// drives signed fractions through the valid/ready channels and checks each reduced
// result against an in-bench gcd reduction; needs only rtl rational_normalizer_unit

module rational_normalizer_unit_tb;

	localparam int WIDTH        = 32;
	localparam int RANDOM_ITEMS = 600;
	// covers the worst euclid chain, a full divider pass per remainder step, plus long stalls
	localparam int IDLE_LIMIT   = 20000;
	// quiet time after the last result, enough for a stray late result to show up
	localparam int DRAIN_TAIL   = 2000;

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [WIDTH-2:0] den_t;

	localparam word_t MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
	localparam word_t MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

	// one reduced fraction as the block should present it
	typedef struct packed {
		word_t num;
		den_t  den;
		logic  zero_den;
	} fraction_t;

	// keeps the expected reductions in order and compares results against them
	class reduction_scoreboard;
		fraction_t pending_reductions[$];
		int        mismatches;

		function new();
			mismatches = 0;
		endfunction

		// normal form of n/d: gcd on magnitudes, sign on the numerator, saturation
		static function fraction_t reduce_fraction(word_t n, word_t d);
			fraction_t res;
			word_t     n_mag, d_mag, a, b, rem, rn, rd;
			logic      flip;
			n_mag = n[WIDTH-1] ? -n : n;
			d_mag = d[WIDTH-1] ? -d : d;
			res.num = '0;
			res.den = den_t'(1);
			res.zero_den = 1'b0;
			if (d_mag == '0) begin
				res.zero_den = 1'b1;
				return res;
			end
			if (n_mag == '0)
				return res;
			a = n_mag;
			b = d_mag;
			while (b != '0) begin
				rem = a % b;
				a = b;
				b = rem;
			end
			rn = n_mag / a;
			rd = d_mag / a;
			// a magnitude of 2^(WIDTH-1) does not fit the unsigned denominator
			if (rd > MOST_POS)
				rd = MOST_POS;
			flip = n[WIDTH-1] ^ d[WIDTH-1];
			// negative -2^(WIDTH-1) is representable, positive one saturates
			if (flip)
				res.num = -rn;
			else
				res.num = (rn > MOST_POS) ? MOST_POS : rn;
			res.den = rd[WIDTH-2:0];
			return res;
		endfunction

		function void note_input(word_t n, word_t d);
			pending_reductions.push_back(reduce_fraction(n, d));
		endfunction

		function int pending();
			return pending_reductions.size();
		endfunction

		task report(string what);
			if (mismatches < 50)
				$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_result(word_t n, den_t d, logic e);
			fraction_t want;
			if (pending_reductions.size() == 0) begin
				report($sformatf("result %0d/%0d flag %b with no item pending",
					$signed(n), d, e));
				return;
			end
			want = pending_reductions.pop_front();
			if (n !== want.num)
				report($sformatf("num_out got %0d want %0d", $signed(n), $signed(want.num)));
			if (d !== want.den)
				report($sformatf("den_out got %0d want %0d", d, want.den));
			if (e !== want.zero_den)
				report($sformatf("zero_den_error got %b want %b", e, want.zero_den));
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	word_t num_in = '0;
	word_t den_in = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t num_out;
	den_t  den_out;
	logic  zero_den_error;

	reduction_scoreboard sb;
	// when set, neither side inserts gaps
	bit quiet_phase = 1'b0;

	rational_normalizer_unit #(
		.WIDTH(WIDTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.num_in        (num_in),
		.den_in        (den_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.num_out       (num_out),
		.den_out       (den_out),
		.zero_den_error(zero_den_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int roll;
		if (quiet_phase)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 25);
		return $urandom_range(60, 300);
	endfunction

	function automatic word_t with_sign(word_t mag, bit neg);
		return neg ? -mag : mag;
	endfunction

	function automatic word_t fibonacci(int k);
		word_t a, b, t;
		a = '0;
		b = word_t'(1);
		repeat (k) begin
			t = a + b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic word_t extreme_value();
		word_t pow;
		pow = word_t'(1) << $urandom_range(0, WIDTH - 1);
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return word_t'(1);
			3: return -word_t'(1);
			4: return pow;
			default: return -pow;
		endcase
	endfunction

	// mix of item classes: zeros, raw random, shared factors, small, extremes, slow chains
	function automatic void random_fraction(output word_t n, output word_t d);
		int    kind, k;
		word_t g, a, b;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			n = $urandom;
			d = $urandom;
			if ($urandom_range(0, 1))
				n = '0;
			else
				d = '0;
		end else if (kind < 38) begin
			n = $urandom;
			d = $urandom;
		end else if (kind < 68) begin
			// common factor so the division by the gcd actually does something
			g = $urandom_range(1, 1 << $urandom_range(1, 20));
			a = $urandom_range(1, MOST_POS / g);
			b = $urandom_range(1, MOST_POS / g);
			n = with_sign(a * g, 1'($urandom_range(0, 1)));
			d = with_sign(b * g, 1'($urandom_range(0, 1)));
		end else if (kind < 80) begin
			n = word_t'($urandom_range(0, 128)) - word_t'(64);
			d = word_t'($urandom_range(0, 128)) - word_t'(64);
		end else if (kind < 94) begin
			n = extreme_value();
			d = extreme_value();
		end else begin
			// consecutive fibonacci numbers give the longest remainder chains
			k = $urandom_range(10, 45);
			n = with_sign(fibonacci(k + 1), 1'($urandom_range(0, 1)));
			d = with_sign(fibonacci(k), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 1)) begin
				g = n;
				n = d;
				d = g;
			end
		end
	endfunction

	// called right after a rising edge; returns at the edge that takes the item
	task automatic send_fraction(word_t n, word_t d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		num_in <= n;
		den_in <= d;
		// ready is settled by the falling edge, so the next rising edge takes the item
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
	endtask

	// sender holds off until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic run_directed();
		// zero denominator, with any numerator
		send_fraction('0, '0);
		send_fraction(word_t'(5), '0);
		send_fraction(MOST_NEG, '0);
		// zero numerator
		send_fraction('0, word_t'(7));
		send_fraction('0, MOST_NEG);
		send_fraction('0, -word_t'(1));
		// all four sign combinations
		send_fraction(word_t'(6), word_t'(4));
		send_fraction(-word_t'(6), word_t'(4));
		send_fraction(word_t'(6), -word_t'(4));
		send_fraction(-word_t'(6), -word_t'(4));
		// most negative input and both saturation paths
		send_fraction(MOST_POS, word_t'(1));
		send_fraction(MOST_NEG, word_t'(1));
		send_fraction(MOST_NEG, -word_t'(1));
		send_fraction(MOST_NEG, MOST_NEG);
		send_fraction(word_t'(1), MOST_NEG);
		send_fraction(-word_t'(1), MOST_NEG);
		send_fraction(MOST_POS, MOST_POS);
		send_fraction(MOST_POS, MOST_NEG);
		send_fraction(word_t'(1), MOST_POS);
		send_fraction(-word_t'(1), -word_t'(1));
		// longest euclid chain that fits the width
		send_fraction(fibonacci(46), fibonacci(45));
		send_fraction(word_t'(12345678), word_t'(87654321));
	endtask

	// receiver: stalls of random length, then ready for a short run
	initial begin
		int stall, run;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = quiet_phase ? 50 : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
		end
	end

	// handshakes are looked at on the falling edge, where every signal is settled
	always @(negedge clk) begin
		int idle_cycles;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(num_in, den_in);
			if (out_valid && out_ready)
				sb.check_result(num_out, den_out, zero_den_error);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		word_t n, d;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// a stretch with no gaps on either side, and one more full drain
			quiet_phase = (i >= 200 && i < 260);
			if (i == 400)
				drain_results();
			random_fraction(n, d);
			send_fraction(n, d);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
